// File: hw/rtl/masked_pixel_to_bgra_unit_macros.svh
// ----------------------------------------------------------------------------
// masked pixel to bgra unit assertion macros
// concurrent assertion helpers sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef MASKED_PIXEL_TO_BGRA_UNIT_MACROS_SVH
`define MASKED_PIXEL_TO_BGRA_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MPB_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mpb assertion failed");
// next-cycle implication
`define MPB_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mpb assertion failed");
`else
`define MPB_ASSERT_IMPL(lbl, a, b)
`define MPB_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// File: hw/rtl/mpb_pkg.sv
// ----------------------------------------------------------------------------
// mpb_pkg
// shared types and constants of the masked pixel to bgra unit
// ----------------------------------------------------------------------------
package mpb_pkg;

  // channel scale 255 = 2^SCALE_BITS - 1
  localparam int unsigned SCALE_BITS = 8;

  localparam int unsigned PORT_BITS = 32;
  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [PORT_BITS-1:0] RED_FIELD_RESET   = 32'h00FF_0000;
  localparam logic [PORT_BITS-1:0] GREEN_FIELD_RESET = 32'h0000_FF00;
  localparam logic [PORT_BITS-1:0] BLUE_FIELD_RESET  = 32'h0000_00FF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RED_FIELD   = 2'd0,
    CFG_GREEN_FIELD = 2'd1,
    CFG_BLUE_FIELD  = 2'd2
  } cfg_index_t;

  // channel slots of the per-channel arrays, same order as the registers
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned NUM_CH   = 3;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra_t;

  // pipeline advance control handed to each channel divider
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

// File: hw/rtl/mpb_div_pipe.sv
// ----------------------------------------------------------------------------
// mpb_div_pipe
// one channel: field times 255, then a restoring divide by the lowest mask
// run, one quotient bit per register stage
// ----------------------------------------------------------------------------
module mpb_div_pipe #(
  parameter int unsigned W = 32
) (
  input  logic                clk,
  input  mpb_pkg::pipe_ctrl_t ctrl,
  input  logic [W-1:0]        value,
  input  logic [W-1:0]        divisor,
  output logic [7:0]          quotient
);
  import mpb_pkg::*;

  localparam int unsigned DW = W + SCALE_BITS;

  // acc holds the unconsumed dividend bits, quotient bits shift in below
  logic [DW-1:0] acc [DW+1];
  logic [W-1:0]  rem [DW+1];

  logic [W:0]    partial [DW];
  logic [W:0]    diff    [DW];
  logic [DW-1:0] ge;

  always_comb begin
    for (int k = 0; k < DW; k++) begin
      partial[k] = {rem[k], acc[k][DW-1]};
      diff[k]    = partial[k] - {1'b0, divisor};
      ge[k]      = (partial[k] >= {1'b0, divisor});
    end
  end

  // value * 255 as (value << 8) - value
  // remainder stays below the divisor, so it fits in W bits
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc[0] <= {value, {SCALE_BITS{1'b0}}} - {{SCALE_BITS{1'b0}}, value};
      rem[0] <= '0;
      for (int k = 0; k < DW; k++) begin
        rem[k+1] <= ge[k] ? diff[k][W-1:0] : partial[k][W-1:0];
        acc[k+1] <= {acc[k][DW-2:0], ge[k]};
      end
    end
  end

  assign quotient = acc[DW][7:0];

endmodule

// File: hw/rtl/masked_pixel_to_bgra_unit.sv
// ----------------------------------------------------------------------------
// masked_pixel_to_bgra_unit
// converts packed raw pixel words to bgra bytes using three channel masks
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the s_t* stream, one word per transaction, and leave on
//   the m_t* stream as one bgra word per transaction, in the same order
//   the channel masks are written over the cfg_* channel (index 0 red,
//   1 green, 2 blue; other indexes are ignored); the user must write them
//   only while no pixel is in flight (not enforced); cfg_ready is always high
// throughput: one pixel per clock, sustained while m_tready stays high
// structure: the input register takes the word at its transaction, then
//   come the times-255 stage, W + 8 restoring divider stages (one quotient
//   bit each) and the output register; W is PIXEL_BITS capped at 32
// reset: rst clears all valid bits and loads the 8-8-8 layout masks
// stall: when m_tready is low the result holds in the output register and
//   the pipeline still moves one more transaction into a skid register;
//   s_tready drops only while the skid register is full, so no transaction
//   is dropped or repeated and s_tready never depends on m_tready
// ----------------------------------------------------------------------------
`include "masked_pixel_to_bgra_unit_macros.svh"

module masked_pixel_to_bgra_unit #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [mpb_pkg::PORT_BITS-1:0]          s_tdata,   // [31:0] pixel_word
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [7:0] blue_out, [15:8] green_out, [23:16] red_out, [31:24] alpha_out
  output logic [mpb_pkg::PORT_BITS-1:0]          m_tdata,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mpb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [mpb_pkg::PORT_BITS-1:0]          cfg_data
);
  import mpb_pkg::*;

  // effective word width: pixels and masks are taken modulo 2^W
  localparam int unsigned W   = (PIXEL_BITS < PORT_BITS) ? PIXEL_BITS : PORT_BITS;
  localparam int unsigned DW  = W + SCALE_BITS;
  // input register + times-255 stage + divider stages
  localparam int unsigned LAT = DW + 2;

  // channel masks and their isolated lowest run of ones (the divisor)
  logic [W-1:0] mask   [NUM_CH];
  logic [W-1:0] lowrun [NUM_CH];

  logic [W-1:0] wr_mask;
  logic [W-1:0] wr_lowbit;
  logic [W-1:0] wr_lowrun;

  // pipeline
  pipe_ctrl_t   ctrl;
  logic [W-1:0] pix;
  logic [LAT-1:0] vld;
  logic [7:0]   quot [NUM_CH];
  bgra_t        res;

  // output register and skid register
  bgra_t out_data;
  bgra_t skid_data;
  logic  skid_valid;
  logic  out_valid_next;
  logic  skid_valid_next;
  logic  load_out;
  logic  out_from_skid;
  logic  load_skid;
  logic  take;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  // lowest run: adding the lowest set bit clears that run and nothing below it
  always_comb begin
    wr_mask   = cfg_data[W-1:0];
    wr_lowbit = wr_mask & (~wr_mask + W'(1));
    wr_lowrun = wr_mask & ~(wr_mask + wr_lowbit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset masks are single runs, so each is its own lowest run
      mask[CH_RED]     <= RED_FIELD_RESET[W-1:0];
      mask[CH_GREEN]   <= GREEN_FIELD_RESET[W-1:0];
      mask[CH_BLUE]    <= BLUE_FIELD_RESET[W-1:0];
      lowrun[CH_RED]   <= RED_FIELD_RESET[W-1:0];
      lowrun[CH_GREEN] <= GREEN_FIELD_RESET[W-1:0];
      lowrun[CH_BLUE]  <= BLUE_FIELD_RESET[W-1:0];
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RED_FIELD: begin
          mask[CH_RED]   <= wr_mask;
          lowrun[CH_RED] <= wr_lowrun;
        end
        CFG_GREEN_FIELD: begin
          mask[CH_GREEN]   <= wr_mask;
          lowrun[CH_GREEN] <= wr_lowrun;
        end
        CFG_BLUE_FIELD: begin
          mask[CH_BLUE]   <= wr_mask;
          lowrun[CH_BLUE] <= wr_lowrun;
        end
        default: begin
          // index beyond the register list, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline, advances as a whole while the skid register is free
  // ---------------------------------------------------------------------------
  assign ctrl.en  = !skid_valid;
  assign s_tready = ctrl.en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      pix <= s_tdata[W-1:0];
    end
  end

  // masked field kept at its place: its low bits are zero just like the
  // divisor's, so the shift cancels out of the quotient
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    mpb_div_pipe #(
      .W(W)
    ) u_div (
      .clk      (clk),
      .ctrl     (ctrl),
      .value    (pix & mask[c]),
      .divisor  (lowrun[c]),
      .quotient (quot[c])
    );
  end

  // zero mask gives a zero channel
  always_comb begin
    res.blue  = (lowrun[CH_BLUE]  == '0) ? 8'd0 : quot[CH_BLUE];
    res.green = (lowrun[CH_GREEN] == '0) ? 8'd0 : quot[CH_GREEN];
    res.red   = (lowrun[CH_RED]   == '0) ? 8'd0 : quot[CH_RED];
    res.alpha = ALPHA_OPAQUE;
  end

  // ---------------------------------------------------------------------------
  // output register with skid
  // ---------------------------------------------------------------------------
  assign take = m_tvalid && m_tready;

  always_comb begin
    out_valid_next  = m_tvalid;
    skid_valid_next = skid_valid;
    load_out        = 1'b0;
    out_from_skid   = 1'b0;
    load_skid       = 1'b0;
    priority if (skid_valid) begin
      // pipeline frozen, drain the skid register first
      out_valid_next  = 1'b1;
      skid_valid_next = !take;
      load_out        = take;
      out_from_skid   = 1'b1;
    end else if (!m_tvalid || take) begin
      out_valid_next = vld[LAT-1];
      load_out       = 1'b1;
    end else begin
      // output held, catch the transaction leaving the pipeline
      skid_valid_next = vld[LAT-1];
      load_skid       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid   <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_from_skid ? skid_data : res;
    end
    if (load_skid) begin
      skid_data <= res;
    end
  end

  assign m_tdata = out_data;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid only fills behind a waiting output
  `MPB_ASSERT_IMPL(a_skid_behind_out, skid_valid, m_tvalid)
  // a held skid transaction is not lost while the receiver stalls
  `MPB_ASSERT_NEXT(a_skid_kept, skid_valid && !m_tready, skid_valid && m_tvalid)
  // a frozen pipeline keeps its valid bits
  `MPB_ASSERT_NEXT(a_pipe_frozen, skid_valid, (!s_tready) || $stable(vld))

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the masked pixel to bgra unit: pixels stream in
// under a series of channel mask layouts (8-8-8, 565, zero, full width,
// split runs and random masks), each result is predicted from the masks in
// force when the pixel was taken, and compared against the output stream
// ----------------------------------------------------------------------------
module tb_top;
  import mpb_pkg::*;

  localparam int unsigned IDLE_PCT        = 11;
  localparam int unsigned STALL_LIMIT     = 2000;   // cycles with no transaction at all
  localparam int unsigned TAIL_CYCLES     = 60;     // pipeline depth is 43 at 32 bits
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned MAX_REPORTS     = 10;

  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [PORT_BITS-1:0]      s_tdata   = '0;    // [31:0] pixel_word
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  // [7:0] blue_out, [15:8] green_out, [23:16] red_out, [31:24] alpha_out
  logic [PORT_BITS-1:0]      m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [PORT_BITS-1:0]      cfg_data  = '0;

  masked_pixel_to_bgra_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pixels waiting for the driver, and bgra words waiting for the output
  logic [PORT_BITS-1:0] pixel_q [$];
  bgra_t                bgra_q  [$];

  // local copy of the channel masks
  logic [PORT_BITS-1:0] red_sel, green_sel, blue_sel;

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  logic        s_took        = 1'b0;
  logic        steady        = 1'b0;   // no idling on either side while set

  // rescale one masked field to 0..255; the run length counts only the lowest
  // run of ones, but every masked bit is extracted, so the quotient may wrap
  function automatic logic [7:0] scale_field(logic [31:0] pixel, logic [31:0] mask);
    int unsigned lsb;
    int unsigned run;
    logic [63:0] field;
    logic [63:0] full_scale;
    logic [63:0] quotient;
    if (mask == '0) begin
      return 8'd0;
    end
    lsb = 0;
    while (!mask[lsb]) lsb++;
    run = 0;
    while (lsb + run < 32 && mask[lsb + run]) run++;
    field = {32'd0, pixel & mask} >> lsb;
    full_scale = (64'd1 << run) - 64'd1;
    quotient = (field * 64'd255) / full_scale;
    return quotient[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // register write, issued only while no pixel is in flight
  // ---------------------------------------------------------------------------
  task automatic write_mask(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(logic [31:0] value);
    pixel_q.push_back(value);
    pixels_queued++;
  endtask

  // every queued pixel taken and every bgra word seen
  task automatic wait_idle();
    do @(negedge clk); while (pixels_queued != pixels_taken || bgra_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // mask copy follows accepted register writes; unused index is dropped
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      red_sel   <= RED_FIELD_RESET;
      green_sel <= GREEN_FIELD_RESET;
      blue_sel  <= BLUE_FIELD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RED_FIELD:   red_sel   <= cfg_data;
        CFG_GREEN_FIELD: green_sel <= cfg_data;
        CFG_BLUE_FIELD:  blue_sel  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input side: predict the bgra word of each accepted pixel transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_predict
    bgra_t want;
    s_took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      want.blue  = scale_field(s_tdata, blue_sel);
      want.green = scale_field(s_tdata, green_sel);
      want.red   = scale_field(s_tdata, red_sel);
      want.alpha = ALPHA_OPAQUE;
      bgra_q.push_back(want);
      pixels_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: pixels and output back-pressure change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      // slot is free: offer the next pixel unless this cycle idles
      if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pixel_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // monitor: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : bgra_monitor
    bgra_t got;
    bgra_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (bgra_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected bgra word %h", $realtime, got);
        end
      end else begin
        want = bgra_q.pop_front();
        if (got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: bgra mismatch  exp b=%h g=%h r=%h a=%h  got b=%h g=%h r=%h a=%h",
                     $realtime, want.blue, want.green, want.red, want.alpha,
                     got.blue, got.green, got.red, got.alpha);
          end
        end
      end
    end
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed layouts first, then random masks and pixels
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_index_t           reg_ids [3];
    logic [31:0]          masks   [3];
    logic [63:0]          run_bits;
    logic [31:0]          pix;
    int unsigned          run;
    int unsigned          lsb;
    int unsigned          calm_phase;

    reg_ids[0] = CFG_RED_FIELD;
    reg_ids[1] = CFG_GREEN_FIELD;
    reg_ids[2] = CFG_BLUE_FIELD;
    calm_phase = $urandom_range(0, RANDOM_PHASES - 1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layout 8-8-8: extremes and each channel alone
    @(posedge clk);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h00FF_0000);
    queue_pixel(32'h0000_FF00);
    queue_pixel(32'h0000_00FF);
    queue_pixel(32'h1234_5678);
    queue_pixel(32'h8080_8080);
    wait_idle();

    // 565 layout, fields of width 5 and 6
    write_mask(CFG_RED_FIELD,   32'h0000_F800);
    write_mask(CFG_GREEN_FIELD, 32'h0000_07E0);
    write_mask(CFG_BLUE_FIELD,  32'h0000_001F);
    @(posedge clk);
    queue_pixel(32'h0000_FFFF);
    queue_pixel(32'h0000_F800);
    queue_pixel(32'h0000_07E0);
    queue_pixel(32'h0000_001F);
    queue_pixel(32'hFFFF_0000);
    wait_idle();

    // all masks zero, then a write to the unused index must change nothing
    write_mask(CFG_RED_FIELD,   32'h0000_0000);
    write_mask(CFG_GREEN_FIELD, 32'h0000_0000);
    write_mask(CFG_BLUE_FIELD,  32'h0000_0000);
    write_mask(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
    @(posedge clk);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hA5A5_A5A5);
    wait_idle();

    // full 32-bit field, top bit alone, bottom bit alone
    write_mask(CFG_RED_FIELD,   32'hFFFF_FFFF);
    write_mask(CFG_GREEN_FIELD, 32'h8000_0000);
    write_mask(CFG_BLUE_FIELD,  32'h0000_0001);
    @(posedge clk);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h8000_0001);
    queue_pixel(32'h7FFF_FFFE);
    queue_pixel(32'h0000_0000);
    wait_idle();

    // masks with several runs of ones: quotient overflows and wraps to 8 bits
    write_mask(CFG_RED_FIELD,   32'h0F0F_0000);
    write_mask(CFG_GREEN_FIELD, 32'h0000_0505);
    write_mask(CFG_BLUE_FIELD,  32'hF000_000F);
    @(posedge clk);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hF000_000F);
    queue_pixel(32'h0F0F_0505);
    queue_pixel(32'h0F00_0000);
    wait_idle();

    // random layouts: zero, arbitrary words, and single runs of any size
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(0, 5))
          0: masks[ch] = '0;
          1: masks[ch] = $urandom();
          default: begin
            run = $urandom_range(1, 32);
            lsb = $urandom_range(0, 32 - run);
            run_bits = ((64'd1 << run) - 64'd1) << lsb;
            masks[ch] = run_bits[31:0];
          end
        endcase
        write_mask(reg_ids[ch], masks[ch]);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_mask(CFG_UNUSED_INDEX, $urandom());
      end
      @(posedge clk);
      steady = (p == calm_phase);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(0, 9))
          0: pix = '0;
          1: pix = '1;
          // only bits under some mask, so fields fill up often
          2, 3: pix = $urandom() & (masks[0] | masks[1] | masks[2]);
          default: pix = $urandom();
        endcase
        queue_pixel(pix);
      end
      wait_idle();
    end

    // let any stray word out of the pipeline before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && bgra_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mpb_pkg.sv
hw/rtl/mpb_div_pipe.sv
hw/rtl/masked_pixel_to_bgra_unit.sv
bench/tb_top.sv
